FILE: hdl/hdmt_pkg.sv
// Package for the hashed direct-mapped memo table.
// Holds the table size, hash constants, command codes and shared word types.
// Depends on nothing.
package hdmt_pkg;

    // Number of table slots; a power of two, so the slot is the low hash bits.
    localparam int TABLE_SLOTS = 1024;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);

    localparam int UNUSED_W = 42;
    localparam int WORD_W   = 64;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    localparam logic [WORD_W-1:0] MIX_MUL_A      = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B      = 64'h94d049bb133111eb;
    localparam logic [WORD_W-1:0] SEED_UNUSED    = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] SEED_SUMS_LOW  = 64'hd1b54a32d192ed03;
    localparam logic [WORD_W-1:0] SEED_SUMS_HIGH = 64'h94d049bb133111eb;

    typedef struct packed {
        logic [UNUSED_W-1:0] unused;
        logic [WORD_W-1:0]   sum_lo;
        logic [WORD_W-1:0]   sum_hi;
    } key_t;

    typedef struct packed {
        logic              command;
        key_t              key;
        logic [WORD_W-1:0] data_lo;
        logic [WORD_W-1:0] data_hi;
    } tbl_op_t;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] read_low;
        logic [WORD_W-1:0] read_high;
        logic              evicted;
    } rsp_word_t;

    typedef struct packed {
        logic              valid;
        key_t              key;
        logic [WORD_W-1:0] data_lo;
        logic [WORD_W-1:0] data_hi;
    } entry_t;

endpackage

FILE: hdl/hdmt_req_if.sv
// Request channel of the memo table: valid, ready and one command word.
// Depends on hdmt_pkg.
interface hdmt_req_if
    import hdmt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                command;
    logic [UNUSED_W-1:0] key_unused;
    logic [WORD_W-1:0]   key_sums_low;
    logic [WORD_W-1:0]   key_sums_high;
    logic [WORD_W-1:0]   data_lo;
    logic [WORD_W-1:0]   data_hi;

    modport source (
        output valid, command, key_unused, key_sums_low, key_sums_high,
               data_lo, data_hi,
        input  ready
    );

    modport sink (
        input  valid, command, key_unused, key_sums_low, key_sums_high,
               data_lo, data_hi,
        output ready
    );
endinterface

FILE: hdl/hdmt_rsp_if.sv
// Response channel of the memo table: valid, ready and one result word.
// Depends on hdmt_pkg.
interface hdmt_rsp_if
    import hdmt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [WORD_W-1:0] read_low;
    logic [WORD_W-1:0] read_high;
    logic              evicted;

    modport source (
        output valid, hit, read_low, read_high, evicted,
        input  ready
    );

    modport sink (
        input  valid, hit, read_low, read_high, evicted,
        output ready
    );
endinterface

FILE: hdl/hashed_direct_mapped_memo_table.sv
// Hashed direct-mapped memo table: one lookup or store word at a time.
// A new word is taken when the previous one has left the core; the hash phase runs
// eight 64-bit products through one shared 32x32 multiplier in three passes each.
// After reset a sweep clears every one of the TABLE_SLOTS (1024) slots before the first word.
// Depends on hdmt_pkg, hdmt_req_if, hdmt_rsp_if, hdmt_hash and hdmt_table.
module hashed_direct_mapped_memo_table
    import hdmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hdmt_req_if.sink   req,
    hdmt_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_TABLE,
        S_PUT
    } top_state_t;

    top_state_t        state_reg;
    logic              out_valid_reg;
    rsp_word_t         out_reg;
    logic              cmd_reg;
    logic [WORD_W-1:0] val_lo_reg;
    logic [WORD_W-1:0] val_hi_reg;
    key_t              key_reg;
    key_t              req_key;
    logic              accept;
    logic              hash_done;
    logic [WORD_W-1:0] hash;
    logic              tbl_start;
    logic              tbl_idle;
    logic              tbl_done;
    tbl_op_t           tbl_op;
    rsp_word_t         tbl_rsp;
    logic              out_free;

    assign req.ready = (state_reg == S_IDLE) && tbl_idle;
    assign accept    = req.valid && req.ready;

    assign req_key.unused = req.key_unused;
    assign req_key.sum_lo = req.key_sums_low;
    assign req_key.sum_hi = req.key_sums_high;

    assign tbl_start      = (state_reg == S_HASH) && hash_done;
    assign tbl_op.command = cmd_reg;
    assign tbl_op.key     = key_reg;
    assign tbl_op.data_lo = val_lo_reg;
    assign tbl_op.data_hi = val_hi_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    hdmt_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (req_key),
        .done  (hash_done),
        .hash  (hash)
    );

    hdmt_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (tbl_start),
        .index  (hash[IDX_W-1:0]),
        .op     (tbl_op),
        .idle   (tbl_idle),
        .done   (tbl_done),
        .result (tbl_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_PUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        state_reg <= S_TABLE;
                    end
                end
                S_TABLE:
                begin
                    if (tbl_done)
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.command;
            key_reg    <= req_key;
            val_lo_reg <= req.data_lo;
            val_hi_reg <= req.data_hi;
        end
        if (state_reg == S_PUT && out_free)
        begin
            out_reg <= tbl_rsp;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_reg.hit;
    assign rsp.read_low  = out_reg.read_low;
    assign rsp.read_high = out_reg.read_high;
    assign rsp.evicted   = out_reg.evicted;

`ifndef ASSERT_OFF
    a_hash_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == S_HASH)
        else $error("hash finished outside the hash phase");

    a_tbl_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_done |-> state_reg == S_TABLE)
        else $error("table finished outside the table phase");

    a_store_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_done && cmd_reg == CMD_STORE |-> !tbl_rsp.hit)
        else $error("store reported a hit");

    a_put_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUT && !out_valid_reg |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not moved to the output register");
`endif

endmodule

FILE: hdl/hdmt_mul64.sv
// Low 64 bits of a 64 by 64 product, built from three 32 by 32 passes.
// Depends on hdmt_pkg.
module hdmt_mul64
    import hdmt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              done,
    output logic [WORD_W-1:0] product
);

    logic              busy_reg;
    logic [1:0]        step_reg;
    logic              done_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [31:0]       m_x;
    logic [31:0]       m_y;
    logic [63:0]       m_p;

    assign m_x = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign m_y = (step_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
    assign m_p = m_x * m_y;

    always_comb
    begin
        case (step_reg)
            2'd0:    acc_next = m_p;
            2'd1:    acc_next = acc_reg + {m_p[31:0], 32'h0};
            2'd2:    acc_next = acc_reg + {m_p[31:0], 32'h0};
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (step_reg == 2'd2);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= 2'd0;
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: hdl/hdmt_hash.sv
// Slot hash sequencer: four mixing rounds over the shared 64-bit multiplier.
// Depends on hdmt_pkg and hdmt_mul64.
module hdmt_hash
    import hdmt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  key_t              key,
    output logic              done,
    output logic [WORD_W-1:0] hash
);

    typedef enum logic [2:0] {
        H_IDLE,
        H_L1,
        H_M1,
        H_L2,
        H_M2
    } hash_state_t;

    hash_state_t       state_reg;
    logic [1:0]        round_reg;
    logic              done_reg;
    key_t              key_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] hash_reg;
    logic [WORD_W-1:0] pre;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic              mul_start;
    logic              mul_done;
    logic [WORD_W-1:0] mul_p;
    logic [WORD_W-1:0] mid;
    logic [WORD_W-1:0] fin;

    always_comb
    begin
        case (round_reg)
            2'd0:    pre = {{(WORD_W-UNUSED_W){1'b0}}, key_reg.unused} + SEED_UNUSED;
            2'd1:    pre = key_reg.sum_lo + SEED_SUMS_LOW;
            2'd2:    pre = key_reg.sum_hi + SEED_SUMS_HIGH;
            default: pre = acc_reg;
        endcase
    end

    assign mul_start = (state_reg == H_L1) || (state_reg == H_L2);
    assign mul_a     = (state_reg == H_L2) ? x_reg : (pre ^ (pre >> 30));
    assign mul_b     = (state_reg == H_L2) ? MIX_MUL_B : MIX_MUL_A;
    assign mid       = mul_p ^ (mul_p >> 27);
    assign fin       = mul_p ^ (mul_p >> 31);

    hdmt_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            round_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == H_M2) && mul_done && (round_reg == 2'd3);
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        round_reg <= 2'd0;
                        state_reg <= H_L1;
                    end
                end
                H_L1:
                begin
                    state_reg <= H_M1;
                end
                H_M1:
                begin
                    if (mul_done)
                    begin
                        state_reg <= H_L2;
                    end
                end
                H_L2:
                begin
                    state_reg <= H_M2;
                end
                H_M2:
                begin
                    if (mul_done)
                    begin
                        if (round_reg == 2'd3)
                        begin
                            state_reg <= H_IDLE;
                        end
                        else
                        begin
                            round_reg <= round_reg + 2'd1;
                            state_reg <= H_L1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == H_IDLE && start)
        begin
            key_reg <= key;
            acc_reg <= '0;
        end
        if (state_reg == H_M1 && mul_done)
        begin
            x_reg <= mid;
        end
        if (state_reg == H_M2 && mul_done)
        begin
            if (round_reg == 2'd3)
            begin
                hash_reg <= fin;
            end
            else
            begin
                acc_reg <= acc_reg ^ fin;
            end
        end
    end

    assign done = done_reg;
    assign hash = hash_reg;

endmodule

FILE: hdl/hdmt_table.sv
// Slot memory with its clearing sweep and the read-compare (and, for a store, write) of one command.
// Depends on hdmt_pkg.
module hdmt_table
    import hdmt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] index,
    input  tbl_op_t          op,
    output logic             idle,
    output logic             done,
    output rsp_word_t        result
);

    typedef enum logic [1:0] {
        T_CLEAR,
        T_IDLE,
        T_CMP
    } tbl_state_t;

    entry_t           mem [TABLE_SLOTS];
    tbl_state_t       state_reg;
    logic [IDX_W-1:0] clr_reg;
    logic             done_reg;
    logic [IDX_W-1:0] idx_reg;
    tbl_op_t          op_reg;
    entry_t           rd_reg;
    rsp_word_t        result_reg;
    rsp_word_t        result_next;
    logic             same;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    assign same = rd_reg.valid && (rd_reg.key == op_reg.key);

    always_comb
    begin
        result_next = '0;
        if (op_reg.command == CMD_STORE)
        begin
            result_next.evicted = rd_reg.valid && !same;
        end
        else if (same)
        begin
            result_next.hit       = 1'b1;
            result_next.read_low  = rd_reg.data_lo;
            result_next.read_high = rd_reg.data_hi;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        if (state_reg == T_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end
        else if (state_reg == T_CMP && op_reg.command == CMD_STORE)
        begin
            wr_en           = 1'b1;
            wr_data.valid   = 1'b1;
            wr_data.key     = op_reg.key;
            wr_data.data_lo = op_reg.data_lo;
            wr_data.data_hi = op_reg.data_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == T_IDLE && start)
        begin
            rd_reg <= mem[index];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == T_CMP);
            case (state_reg)
                T_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IDX_W'(TABLE_SLOTS - 1))
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                T_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= T_CMP;
                    end
                end
                T_CMP:
                begin
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && start)
        begin
            idx_reg <= index;
            op_reg  <= op;
        end
        if (state_reg == T_CMP)
        begin
            result_reg <= result_next;
        end
    end

    assign idle   = (state_reg == T_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
